FILE: rtl/assert_macros.svh
// assertion helpers used by src_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked at every rising clock edge out of reset
`define SRC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/src_pkg.sv
package src_pkg;

  localparam int RADIX_W = 5;
  localparam int CHAR_W = 7;
  localparam int DIGIT_W = 4;

  // quotient bits resolved per divider cycle
  localparam int STEPS_PER_CYCLE = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

FILE: rtl/src_if.sv
interface src_num_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface src_text_if import src_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

interface src_cfg_if import src_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/src_front.sv
module src_front #(
  parameter int VALUE_WIDTH = 32
) (
  src_num_if.sink                num,
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [VALUE_WIDTH:0]   push_data
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;

  // magnitude as unsigned so the most negative value survives negation
  always_comb begin
    raw = num.value;
    neg = raw[VALUE_WIDTH-1];
    mag = neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
  end

  assign push_valid = num.valid;
  assign num.ready = push_ready;
  assign push_data = {neg, mag};

endmodule

FILE: rtl/src_queue.sv
module src_queue #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_data = slot[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= push_data;
  end

endmodule

FILE: rtl/src_back.sv
`include "assert_macros.svh"

module src_back import src_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [RADIX_W-1:0] radix,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [VALUE_WIDTH:0] pop_data,
  src_text_if.source         text
);

  localparam int CHUNKS = (VALUE_WIDTH + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
  localparam int DW = CHUNKS * STEPS_PER_CYCLE;
  localparam int KW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_EMIT = 3'b100
  } back_state_t;

  back_state_t        state;
  logic [DW-1:0]      quo;
  logic [DIGIT_W-1:0] rem;
  logic [KW-1:0]      chunk;
  logic [CW-1:0]      count;
  logic               neg;
  logic [CW-1:0]      remaining;
  logic               sign_pending;
  logic               rd_vld;
  logic               rd_sign;
  logic               rd_last;
  logic [DIGIT_W-1:0] rd_digit;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic [RADIX_W-1:0] eff;
  logic [DW-1:0]      q_w;
  logic [DIGIT_W-1:0] r_w;
  logic [RADIX_W-1:0] t;
  logic               chunk_last;
  logic               stop;
  logic               move;
  logic               issue;
  logic [AW-1:0]      rd_addr;
  logic [DIGIT_W-1:0] stack [MAX_DIGITS];

  always_comb begin
    if (radix < RADIX_MIN) eff = RADIX_MIN;
    else if (radix > RADIX_MAX) eff = RADIX_MAX;
    else eff = radix;
  end

  // restoring long division, a few quotient bits per cycle; remainder stays below base
  always_comb begin
    q_w = quo;
    r_w = rem;
    t = '0;
    for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
      t = {r_w, q_w[DW-1]};
      q_w = {q_w[DW-2:0], 1'b0};
      if (t >= eff) begin
        r_w = DIGIT_W'(t - eff);
        q_w[0] = 1'b1;
      end else begin
        r_w = t[DIGIT_W-1:0];
      end
    end
  end

  assign chunk_last = (chunk == KW'(CHUNKS - 1));
  assign stop = (q_w == '0) || (count == CW'(MAX_DIGITS - 1));

  assign move = rd_vld && (!out_valid || text.ready);
  assign issue = (state == B_EMIT) && (sign_pending || (remaining != '0))
                 && (!rd_vld || move);
  assign rd_addr = AW'(remaining - CW'(1));

  assign pop_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      count <= '0;
      chunk <= '0;
      neg <= 1'b0;
      remaining <= '0;
      sign_pending <= 1'b0;
      rd_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            neg <= pop_data[VALUE_WIDTH];
            quo <= DW'(pop_data[VALUE_WIDTH-1:0]);
            rem <= '0;
            chunk <= '0;
            count <= '0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          quo <= q_w;
          if (chunk_last) begin
            rem <= '0;
            chunk <= '0;
            count <= count + CW'(1);
            if (stop) begin
              remaining <= count + CW'(1);
              sign_pending <= neg;
              state <= B_EMIT;
            end
          end else begin
            rem <= r_w;
            chunk <= chunk + KW'(1);
          end
        end
        B_EMIT: begin
          if (!sign_pending && (remaining == '0) && !rd_vld) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase

      // sign goes first, then digits popped from the top of the stack
      if (issue) begin
        rd_vld <= 1'b1;
        if (sign_pending) begin
          rd_sign <= 1'b1;
          rd_last <= 1'b0;
          sign_pending <= 1'b0;
        end else begin
          rd_sign <= 1'b0;
          rd_last <= (remaining == CW'(1));
          remaining <= remaining - CW'(1);
        end
      end else if (move) begin
        rd_vld <= 1'b0;
      end

      if (move) begin
        out_valid <= 1'b1;
        out_char <= rd_sign ? CHAR_MINUS : digit_char(rd_digit);
        out_last <= rd_last;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == B_DIV) && chunk_last) stack[count[AW-1:0]] <= r_w;
  end

  always_ff @(posedge clk) begin
    if (issue && !sign_pending) rd_digit <= stack[rd_addr];
  end

  assign text.valid = out_valid;
  assign text.char_code = out_char;
  assign text.last = out_last;

  `SRC_ASSERT(a_count_bound, clk, rst, count <= CW'(MAX_DIGITS), "digit count past stack depth")
  `SRC_ASSERT_NXT(a_pop_starts_div, clk, rst, (state == B_IDLE) && pop_valid,
                  state == B_DIV, "queue pop did not start a division")
  `SRC_ASSERT_NXT(a_rem_below_base, clk, rst, state == B_DIV,
                  (state != B_DIV) || ({1'b0, rem} < eff), "partial remainder not below base")
  `SRC_ASSERT_NXT(a_last_drains, clk, rst, move && rd_last,
                  (remaining == '0) && !sign_pending && !rd_vld, "last word left work behind")

endmodule

FILE: rtl/signed_radix_converter.sv
// signed_radix_converter: signed integer to ascii text in a base from 2 to 16
//
// channels: num takes one signed value per word; text returns one ascii
// character per word, '-' first for negatives, then digits most significant
// first from 0-9 and A-F, with last set on the final character. cfg writes
// the 5-bit radix (0 and 1 act as 2, above 16 acts as 16); write it only
// while no conversion is in flight. cfg is always ready.
// flow: a value passes a two-word queue, then the divider works out its
// digits least significant first into a digit stack. characters then leave
// at one per cycle while the receiver is ready, read back from the digit
// stack through its registered read port. one conversion is divided at a
// time; the queue takes up to two more values meanwhile.
// reset: radix returns to 2, queue and output are emptied.
// receiver stall: the output register holds its word and the stack read
// stage holds one more; the next division waits until the last digit of
// the current one has left the read stage, and the queue fills behind it.
module signed_radix_converter import src_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS = 32
) (
  input logic        clk,
  input logic        rst,
  src_num_if.sink    num,
  src_text_if.source text,
  src_cfg_if.sink    cfg
);

  logic [RADIX_W-1:0]   radix;
  logic                 push_valid;
  logic                 push_ready;
  logic [VALUE_WIDTH:0] push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [VALUE_WIDTH:0] pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg.valid) begin
      radix <= cfg.data;
    end
  end

  src_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .num        (num),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  src_queue #(
    .WIDTH(VALUE_WIDTH + 1)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  src_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .text      (text)
  );

endmodule

FILE: tb/signed_radix_converter_tb.sv
`timescale 1ns / 100ps

module signed_radix_converter_tb;
  import src_pkg::*;

  localparam int VALUE_W = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PCT = 34;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;

  typedef enum logic {FEED_VALUE, FEED_RADIX} feed_kind_t;

  typedef struct {
    feed_kind_t                kind;
    logic signed [VALUE_W-1:0] value;
    logic [RADIX_W-1:0]        radix;
  } feed_item_t;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_word_t;

  logic clk;
  logic rst;

  src_num_if #(.VALUE_WIDTH(VALUE_W)) num_bus ();
  src_text_if text_bus ();
  src_cfg_if cfg_bus ();

  signed_radix_converter #(
    .VALUE_WIDTH(VALUE_W),
    .MAX_DIGITS(32)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .num(num_bus),
    .text(text_bus),
    .cfg(cfg_bus)
  );

  feed_item_t         feed_q[$];
  text_word_t         expected_text[$];
  logic [RADIX_W-1:0] cur_radix;
  bit                 num_took;
  bit                 cfg_took;
  int                 values_sent;
  int                 chars_seen;
  int                 radix_writes;
  int                 mismatches;
  int                 stall_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // text of one value in the current base, sign first, top digit first
  function automatic void queue_text_of(input logic signed [VALUE_W-1:0] v,
                                        input logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] base;
    logic [3:0]         digits[VALUE_W];
    int                 n;
    logic [3:0]         d;
    text_word_t         w;
    base = (r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r;
    mag = v[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(v)) : VALUE_W'(v);
    n = 0;
    do begin
      digits[n] = 4'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      w.code = CHAR_MINUS;
      w.last = 1'b0;
      expected_text.push_back(w);
    end
    for (int i = n - 1; i >= 0; i--) begin
      d = digits[i];
      w.code = (d < 10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - 10);
      w.last = (i == 0);
      expected_text.push_back(w);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  function automatic void add_value(input logic signed [VALUE_W-1:0] v);
    feed_item_t it;
    it.kind = FEED_VALUE;
    it.value = v;
    it.radix = '0;
    feed_q.push_back(it);
  endfunction

  function automatic void add_radix(input logic [RADIX_W-1:0] r);
    feed_item_t it;
    it.kind = FEED_RADIX;
    it.value = '0;
    it.radix = r;
    feed_q.push_back(it);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6: begin
        v = $urandom_range(300);
        if ($urandom_range(1)) v = -v;
      end
      7: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 1;
          2: v = '1;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // sampling, prediction and checking
  always @(posedge clk) begin
    text_word_t want;
    if (rst) begin
      cur_radix = RADIX_RESET;
      num_took = 0;
      cfg_took = 0;
      stall_cycles = 0;
    end else begin
      num_took = num_bus.valid && num_bus.ready;
      cfg_took = cfg_bus.valid && cfg_bus.ready;
      if (text_bus.valid && text_bus.ready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          note_mismatch($sformatf("unexpected word char=%h last=%b",
                                  text_bus.char_code, text_bus.last));
        end else begin
          want = expected_text.pop_front();
          if (text_bus.char_code !== want.code || text_bus.last !== want.last) begin
            note_mismatch($sformatf("word %0d: expected char=%h last=%b, got char=%h last=%b",
                                    chars_seen, want.code, want.last,
                                    text_bus.char_code, text_bus.last));
          end
        end
      end
      if (num_took) begin
        queue_text_of(num_bus.value, cur_radix);
        values_sent++;
      end
      if (cfg_took) begin
        cur_radix = cfg_bus.data;
        radix_writes++;
      end
      if (num_took || cfg_took || (text_bus.valid && text_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // driver: new words and ready change on the falling edge
  always @(negedge clk) begin
    feed_item_t it;
    bit hold_num;
    bit hold_cfg;
    bit gap;
    bit steady_send;
    bit steady_recv;
    if (rst) begin
      num_bus.valid <= 1'b0;
      num_bus.value <= '0;
      cfg_bus.valid <= 1'b0;
      cfg_bus.data <= '0;
      text_bus.ready <= 1'b0;
    end else begin
      steady_send = values_sent >= 140 && values_sent < 190;
      steady_recv = chars_seen >= 1200 && chars_seen < 1700;
      hold_num = num_bus.valid && !num_took;
      hold_cfg = cfg_bus.valid && !cfg_took;
      gap = !steady_send && ($urandom_range(99) < IDLE_PCT);
      text_bus.ready <= steady_recv || ($urandom_range(99) >= IDLE_PCT);
      // radix writes wait until every pending character has come back
      if (!hold_num && !hold_cfg && !gap && feed_q.size() != 0 &&
          (feed_q[0].kind == FEED_VALUE || expected_text.size() == 0)) begin
        it = feed_q.pop_front();
        if (it.kind == FEED_VALUE) begin
          num_bus.valid <= 1'b1;
          num_bus.value <= it.value;
          cfg_bus.valid <= 1'b0;
        end else begin
          cfg_bus.valid <= 1'b1;
          cfg_bus.data <= it.radix;
          num_bus.valid <= 1'b0;
        end
      end else begin
        num_bus.valid <= hold_num;
        cfg_bus.valid <= hold_cfg;
      end
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: %0d cycles without a word, %0d characters still due",
             stall_cycles, expected_text.size());
    $display("** signed_radix_converter: FAILED **");
    $finish;
  end

  initial begin
    logic [RADIX_W-1:0] phase_radix[20];
    phase_radix = '{10, 16, 2, 0, 31, 17, 1, 3, 7, 8, 13, 5, 9, 4, 6, 11, 12, 14, 15, 10};
    rst = 1'b1;
    num_bus.valid = 1'b0;
    num_bus.value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    text_bus.ready = 1'b0;
    values_sent = 0;
    chars_seen = 0;
    radix_writes = 0;
    mismatches = 0;
    stall_cycles = 0;

    // directed: reset radix of 2, then hex digits, out-of-range radix values 0 and 31, then bases 10 and 3
    add_value(0);
    add_value(1);
    add_value(-1);
    add_value(32'sh7FFF_FFFF);
    add_value(32'sh8000_0000);
    add_value(5);
    add_value(-6);
    add_radix(RADIX_MAX);
    add_value(32'shFEDC_BA98);
    add_value(32'sh0123_4567);
    add_value(32'sh89AB_CDEF);
    add_value(32'sh7FFF_FFFF);
    add_value(32'sh8000_0000);
    add_value(0);
    add_radix(0);
    add_value(32'sh8000_0000);
    add_value(255);
    add_radix(31);
    add_value(-1);
    add_value(32'sh7FFF_FFFF);
    add_radix(10);
    add_value(32'sh8000_0000);
    add_value(32'sh7FFF_FFFF);
    add_value(0);
    add_value(-10);
    add_radix(3);
    add_value(32'sh7FFF_FFFF);

    foreach (phase_radix[p]) begin
      add_radix(phase_radix[p]);
      repeat (13) add_value(pick_value());
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || num_bus.valid || cfg_bus.valid ||
           expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("converted %0d values into %0d characters across %0d radix writes",
             values_sent, chars_seen, radix_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("** signed_radix_converter: PASSED **");
    end else begin
      $display("** signed_radix_converter: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/src_pkg.sv
rtl/src_if.sv
rtl/src_front.sv
rtl/src_queue.sv
rtl/src_back.sv
rtl/signed_radix_converter.sv
tb/signed_radix_converter_tb.sv
